// ----- hdl/rab_pkg.sv -----
// ---------------------------------------------------------------------------
// rab_pkg: shared types and constants for the rectangle alpha blender
// Sizes of the rectangle counters, register fields and the config index codes.
// ---------------------------------------------------------------------------
package rab_pkg;

    // Largest rectangle side in pixels
    localparam int MAX_DIM    = 4096;
    localparam int CNT_W      = $clog2(MAX_DIM);
    localparam int DIM_W      = CNT_W + 1;

    localparam int POS_W      = 12;
    localparam int SIZE_W     = 13;
    localparam int COLOR_W    = 8;
    localparam int IDX_W      = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Row term (rect_y + row) and its product with the stride
    localparam int ROW_W      = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
    localparam int PROD_W     = ROW_W + SIZE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECT_X       = 3'd0,
        CFG_RECT_Y       = 3'd1,
        CFG_RECT_WIDTH   = 3'd2,
        CFG_RECT_HEIGHT  = 3'd3,
        CFG_SCREEN_WIDTH = 3'd4
    } cfg_reg_t;

endpackage

// ----- hdl/rect_alpha_blend_core.sv -----
// ---------------------------------------------------------------------------
// rect_alpha_blend_core: alpha blender for a rectangle over a framebuffer
// Blends source over destination bytes and gives the framebuffer pixel index.
// ---------------------------------------------------------------------------
// Usage:
//   Pixels of the rectangle enter in row-major order on the input channel
//   (in_valid / in_stall): source blue, green, red, alpha and the current
//   destination bytes. Each beat yields one result beat on the output channel
//   (out_valid / out_stall): pixel index, blended bytes and last_pixel, which
//   marks the final pixel of the rectangle; the next beat starts it again.
//   An accepted beat goes into the input register, then into the
//   result register, which drives out_valid. Throughput: one pixel per
//   clock without stall, set by the input register and the result register
//   with one blend multiplier per byte and the index multiplier in between.
//   A stalled result holds; the input register keeps accepting until it is
//   full, so in_stall follows out_stall one stage behind.
//   Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data, written
//   while the block is idle. cfg_ready is always high; unknown indexes drop.
//   Reset: rect_x 0, rect_y 0, width, height and stride 1, counters at the
//   first pixel, both stages empty.
// ---------------------------------------------------------------------------
module rect_alpha_blend_core (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rab_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rab_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rab_pkg::COLOR_W-1:0]     src_blue,
    input  logic [rab_pkg::COLOR_W-1:0]     src_green,
    input  logic [rab_pkg::COLOR_W-1:0]     src_red,
    input  logic [rab_pkg::COLOR_W-1:0]     alpha,
    input  logic [rab_pkg::COLOR_W-1:0]     dst_blue,
    input  logic [rab_pkg::COLOR_W-1:0]     dst_green,
    input  logic [rab_pkg::COLOR_W-1:0]     dst_red,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rab_pkg::IDX_W-1:0]       pixel_index,
    output logic [rab_pkg::COLOR_W-1:0]     out_blue,
    output logic [rab_pkg::COLOR_W-1:0]     out_green,
    output logic [rab_pkg::COLOR_W-1:0]     out_red,
    output logic                            last_pixel
);
    import rab_pkg::*;

    // Clamp a size register: zero acts as one, oversize as MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [SIZE_W-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        if (v == '0)
            t = 32'd1;
        else if (t > 32'(MAX_DIM))
            t = 32'(MAX_DIM);
        return t[DIM_W-1:0];
    endfunction

    // (a*s + (255-a)*d) / 255 as 255*d + a*(s-d), then exact divide by 255
    function automatic logic [COLOR_W-1:0] blend(input logic [COLOR_W-1:0] a,
                                                 input logic [COLOR_W-1:0] s,
                                                 input logic [COLOR_W-1:0] d);
        logic signed [8:0]  diff;
        logic signed [17:0] prod;
        logic [17:0]        base;
        logic [17:0]        mix;
        logic [17:0]        q;
        diff = $signed({1'b0, s}) - $signed({1'b0, d});
        prod = $signed({1'b0, a}) * diff;
        base = ({10'b0, d} << 8) - {10'b0, d};
        mix  = base + $unsigned(prod);
        q    = mix + 18'd1 + (mix >> 8);
        return q[15:8];
    endfunction

    // Configuration registers
    logic [POS_W-1:0]  rect_x_reg;
    logic [POS_W-1:0]  rect_y_reg;
    logic [SIZE_W-1:0] rect_width_reg;
    logic [SIZE_W-1:0] rect_height_reg;
    logic [SIZE_W-1:0] screen_width_reg;

    // Rectangle walk
    logic [CNT_W-1:0]  col_reg, col_next;
    logic [CNT_W-1:0]  row_reg, row_next;

    // Input stage
    logic              s1_valid_reg;
    logic [COLOR_W-1:0] s1_src_b_reg, s1_src_g_reg, s1_src_r_reg, s1_alpha_reg;
    logic [COLOR_W-1:0] s1_dst_b_reg, s1_dst_g_reg, s1_dst_r_reg;
    logic [CNT_W-1:0]  s1_col_reg;
    logic [CNT_W-1:0]  s1_row_reg;
    logic              s1_last_reg;

    // Result stage
    logic              out_valid_reg;
    logic [IDX_W-1:0]  pixel_index_reg, pixel_index_next;
    logic [COLOR_W-1:0] out_blue_reg, out_green_reg, out_red_reg;
    logic              last_reg;

    logic              in_accept;
    logic              s2_load;
    logic [DIM_W-1:0]  eff_w, eff_h;
    logic [DIM_W-1:0]  col_plus, row_plus;
    logic              row_end, rect_end;
    logic [ROW_W-1:0]  row_sum, col_sum;
    logic [PROD_W-1:0] row_prod;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_x_reg       <= '0;
            rect_y_reg       <= '0;
            rect_width_reg   <= SIZE_W'(1);
            rect_height_reg  <= SIZE_W'(1);
            screen_width_reg <= SIZE_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_RECT_X:       rect_x_reg       <= cfg_data[POS_W-1:0];
                CFG_RECT_Y:       rect_y_reg       <= cfg_data[POS_W-1:0];
                CFG_RECT_WIDTH:   rect_width_reg   <= cfg_data;
                CFG_RECT_HEIGHT:  rect_height_reg  <= cfg_data;
                CFG_SCREEN_WIDTH: screen_width_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Handshake: result stage frees when empty or taken; input stage then moves
    assign s2_load   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s2_load;
    assign in_accept = in_valid && !in_stall;

    // Counter step
    assign eff_w    = eff_dim(rect_width_reg);
    assign eff_h    = eff_dim(rect_height_reg);
    assign col_plus = DIM_W'(col_reg) + DIM_W'(1);
    assign row_plus = DIM_W'(row_reg) + DIM_W'(1);
    assign row_end  = (col_plus >= eff_w);
    assign rect_end = row_end && (row_plus >= eff_h);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_accept)
        begin
            if (rect_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_end)
            begin
                col_next = '0;
                row_next = row_plus[CNT_W-1:0];
            end
            else
            begin
                col_next = col_plus[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s2_load)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_src_b_reg <= src_blue;
            s1_src_g_reg <= src_green;
            s1_src_r_reg <= src_red;
            s1_alpha_reg <= alpha;
            s1_dst_b_reg <= dst_blue;
            s1_dst_g_reg <= dst_green;
            s1_dst_r_reg <= dst_red;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            s1_last_reg  <= rect_end;
        end
    end

    // Pixel index: (rect_y + row) * stride + rect_x + col, wrapped to 24 bits
    assign row_sum          = ROW_W'(rect_y_reg) + ROW_W'(s1_row_reg);
    assign col_sum          = ROW_W'(rect_x_reg) + ROW_W'(s1_col_reg);
    assign row_prod         = PROD_W'(row_sum) * PROD_W'(screen_width_reg);
    assign pixel_index_next = row_prod[IDX_W-1:0] + IDX_W'(col_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            pixel_index_reg <= pixel_index_next;
            out_blue_reg    <= blend(s1_alpha_reg, s1_src_b_reg, s1_dst_b_reg);
            out_green_reg   <= blend(s1_alpha_reg, s1_src_g_reg, s1_dst_g_reg);
            out_red_reg     <= blend(s1_alpha_reg, s1_src_r_reg, s1_dst_r_reg);
            last_reg        <= s1_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = pixel_index_reg;
    assign out_blue    = out_blue_reg;
    assign out_green   = out_green_reg;
    assign out_red     = out_red_reg;
    assign last_pixel  = last_reg;

endmodule

// ----- hdl/rab_checker.sv -----
// ---------------------------------------------------------------------------
// rab_checker: port-level checks for the rectangle alpha blender
// Watches the top level's channels over time; bound to every instance.
// ---------------------------------------------------------------------------
module rab_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [rab_pkg::IDX_W-1:0]    pixel_index,
    input  logic [rab_pkg::COLOR_W-1:0]  out_blue,
    input  logic [rab_pkg::COLOR_W-1:0]  out_green,
    input  logic [rab_pkg::COLOR_W-1:0]  out_red,
    input  logic                         last_pixel
);
    import rab_pkg::*;

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(pixel_index) && $stable(out_blue)
            && $stable(out_green) && $stable(out_red) && $stable(last_pixel))
        else $error("stalled result beat changed");

    // Input backs up only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with the result side free");

    // An empty result stage fills only from an accepted input beat, via the input register
    a_fill_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result beat without a matching input beat");

endmodule

bind rect_alpha_blend_core rab_checker u_rab_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_index (pixel_index),
    .out_blue    (out_blue),
    .out_green   (out_green),
    .out_red     (out_red),
    .last_pixel  (last_pixel)
);

// ----- tb/rab_blend_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rab_blend_checker: result checker for the rectangle alpha blender
// Tracks register writes and accepted pixels, predicts the blended bytes,
// pixel index and last-pixel flag, and compares them with the output beats.
// ---------------------------------------------------------------------------
module rab_blend_checker (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [rab_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rab_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [rab_pkg::COLOR_W-1:0]     src_blue,
    input  logic [rab_pkg::COLOR_W-1:0]     src_green,
    input  logic [rab_pkg::COLOR_W-1:0]     src_red,
    input  logic [rab_pkg::COLOR_W-1:0]     alpha,
    input  logic [rab_pkg::COLOR_W-1:0]     dst_blue,
    input  logic [rab_pkg::COLOR_W-1:0]     dst_green,
    input  logic [rab_pkg::COLOR_W-1:0]     dst_red,

    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [rab_pkg::IDX_W-1:0]       pixel_index,
    input  logic [rab_pkg::COLOR_W-1:0]     out_blue,
    input  logic [rab_pkg::COLOR_W-1:0]     out_green,
    input  logic [rab_pkg::COLOR_W-1:0]     out_red,
    input  logic                            last_pixel,

    output int                              fail_count,
    output int                              pending,
    output int                              beats_checked,
    output int                              rect_ends
);

    import rab_pkg::*;

    localparam int FULL_ALPHA = 255;

    typedef struct packed {
        logic [IDX_W-1:0]   index;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic               last;
    } blended_px_t;

    blended_px_t        blended_q[$];

    logic [POS_W-1:0]   win_x;
    logic [POS_W-1:0]   win_y;
    logic [SIZE_W-1:0]  win_w;
    logic [SIZE_W-1:0]  win_h;
    logic [SIZE_W-1:0]  stride;
    logic [CNT_W-1:0]   col_pos;
    logic [CNT_W-1:0]   row_pos;

    // Zero acts as one, anything past the largest side acts as that side
    function automatic int clamp_dim(input logic [SIZE_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    function automatic logic [COLOR_W-1:0] mix_byte(input logic [COLOR_W-1:0] a,
                                                    input logic [COLOR_W-1:0] s,
                                                    input logic [COLOR_W-1:0] d);
        int acc;
        acc = (int'(a) * int'(s) + (FULL_ALPHA - int'(a)) * int'(d)) / FULL_ALPHA;
        return acc[COLOR_W-1:0];
    endfunction

    task automatic flag_field(input string field, input longint want_v, input longint got_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        blended_px_t want;
        int          w_eff;
        int          h_eff;
        logic        row_done;
        logic        rect_done;
        longint      lin;

        if (!rst_n)
        begin
            blended_q.delete();
            win_x   = '0;
            win_y   = '0;
            win_w   = SIZE_W'(1);
            win_h   = SIZE_W'(1);
            stride  = SIZE_W'(1);
            col_pos = '0;
            row_pos = '0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RECT_X:       win_x  = cfg_data[POS_W-1:0];
                    CFG_RECT_Y:       win_y  = cfg_data[POS_W-1:0];
                    CFG_RECT_WIDTH:   win_w  = cfg_data[SIZE_W-1:0];
                    CFG_RECT_HEIGHT:  win_h  = cfg_data[SIZE_W-1:0];
                    CFG_SCREEN_WIDTH: stride = cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                w_eff     = clamp_dim(win_w);
                h_eff     = clamp_dim(win_h);
                // a counter at or past a shrunken bound ends its row or rectangle
                row_done  = (int'(col_pos) + 1 >= w_eff);
                rect_done = row_done && (int'(row_pos) + 1 >= h_eff);
                lin = (longint'(win_y) + longint'(row_pos)) * longint'(stride)
                    + longint'(win_x) + longint'(col_pos);

                want.index = lin[IDX_W-1:0];
                want.blue  = mix_byte(alpha, src_blue, dst_blue);
                want.green = mix_byte(alpha, src_green, dst_green);
                want.red   = mix_byte(alpha, src_red, dst_red);
                want.last  = rect_done;
                blended_q.push_back(want);

                if (rect_done)
                begin
                    col_pos = '0;
                    row_pos = '0;
                end
                else if (row_done)
                begin
                    col_pos = '0;
                    row_pos = row_pos + 1'b1;
                end
                else
                begin
                    col_pos = col_pos + 1'b1;
                end
            end

            if (out_valid && !out_stall)
            begin
                if (blended_q.size() == 0)
                begin
                    $display("%0t: output beat with nothing expected, index %0d",
                             $time, pixel_index);
                    fail_count++;
                end
                else
                begin
                    want = blended_q.pop_front();
                    if (pixel_index !== want.index)
                        flag_field("pixel_index", longint'(want.index),
                                   longint'(pixel_index));
                    if (out_blue !== want.blue)
                        flag_field("out_blue", longint'(want.blue), longint'(out_blue));
                    if (out_green !== want.green)
                        flag_field("out_green", longint'(want.green), longint'(out_green));
                    if (out_red !== want.red)
                        flag_field("out_red", longint'(want.red), longint'(out_red));
                    if (last_pixel !== want.last)
                        flag_field("last_pixel", longint'(want.last), longint'(last_pixel));
                    beats_checked++;
                    if (want.last)
                        rect_ends++;
                end
            end

            pending = blended_q.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for the rectangle alpha blender core
// Programs rectangle windows, streams pixels under four flow-control modes
// and one long output hold, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module tb_top;

    import rab_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam int PHASES        = 12;
    localparam int PX_PER_PHASE  = 96;
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_CYCLES   = 8;
    localparam int RUN_LIMIT_NS  = 2_000_000;

    typedef enum int {
        FLOW_FREE,
        FLOW_SRC_GAPS,
        FLOW_SINK_STALLS,
        FLOW_BOTH
    } flow_mode_t;

    typedef struct packed {
        logic [COLOR_W-1:0] src_b;
        logic [COLOR_W-1:0] src_g;
        logic [COLOR_W-1:0] src_r;
        logic [COLOR_W-1:0] a;
        logic [COLOR_W-1:0] dst_b;
        logic [COLOR_W-1:0] dst_g;
        logic [COLOR_W-1:0] dst_r;
    } src_px_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [COLOR_W-1:0]     src_blue;
    logic [COLOR_W-1:0]     src_green;
    logic [COLOR_W-1:0]     src_red;
    logic [COLOR_W-1:0]     alpha;
    logic [COLOR_W-1:0]     dst_blue;
    logic [COLOR_W-1:0]     dst_green;
    logic [COLOR_W-1:0]     dst_red;
    logic                   out_valid;
    logic                   out_stall;
    logic [IDX_W-1:0]       pixel_index;
    logic [COLOR_W-1:0]     out_blue;
    logic [COLOR_W-1:0]     out_green;
    logic [COLOR_W-1:0]     out_red;
    logic                   last_pixel;

    int                     fail_count;
    int                     pending;
    int                     beats_checked;
    int                     rect_ends;
    int                     cfg_writes = 0;

    flow_mode_t             flow = FLOW_FREE;
    bit                     hold_req = 1'b0;

    rect_alpha_blend_core u_top (.*);

    rab_blend_checker u_checker (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("%0t: run did not finish in time", $time);
        $display("*** FAILED ***");
        $finish;
    end

    // Output side: random stalls by mode, plus one long hold on request
    initial
    begin
        int r;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            r = $urandom_range(99);
            out_stall <= (flow == FLOW_SINK_STALLS && r < 63) || (flow == FLOW_BOTH && r < 24);
        end
    end

    function automatic bit src_gap();
        int r;
        r = $urandom_range(99);
        return (flow == FLOW_SRC_GAPS && r < 63) || (flow == FLOW_BOTH && r < 24);
    endfunction

    function automatic src_px_t make_px(input int sb, input int sg, input int sr, input int a,
                                        input int db, input int dg, input int dr);
        src_px_t p;
        p.src_b = 8'(sb);
        p.src_g = 8'(sg);
        p.src_r = 8'(sr);
        p.a     = 8'(a);
        p.dst_b = 8'(db);
        p.dst_g = 8'(dg);
        p.dst_r = 8'(dr);
        return p;
    endfunction

    function automatic src_px_t random_px();
        src_px_t p;
        int      pick;
        p = make_px($urandom_range(255), $urandom_range(255), $urandom_range(255),
                    $urandom_range(255), $urandom_range(255), $urandom_range(255),
                    $urandom_range(255));
        // lean on fully transparent and fully opaque now and then
        pick = $urandom_range(7);
        if (pick == 0)
            p.a = 8'h00;
        else if (pick == 1)
            p.a = 8'hFF;
        return p;
    endfunction

    task automatic send_pixel(input src_px_t p);
        while (src_gap())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        src_blue  <= p.src_b;
        src_green <= p.src_g;
        src_red   <= p.src_r;
        alpha     <= p.a;
        dst_blue  <= p.dst_b;
        dst_green <= p.dst_g;
        dst_red   <= p.dst_r;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_pixel(random_px());
    endtask

    // Drop valid and wait until every predicted beat has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Valid stays high across back-to-back writes; the caller drops it
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_writes++;
    endtask

    task automatic program_window(input int x, input int y, input int w, input int h,
                                  input int s, input int junk);
        drain_results();
        cfg_write(CFG_RECT_X, CFG_DATA_W'(x));
        cfg_write(CFG_RECT_Y, CFG_DATA_W'(y));
        cfg_write(CFG_RECT_WIDTH, CFG_DATA_W'(w));
        cfg_write(CFG_RECT_HEIGHT, CFG_DATA_W'(h));
        cfg_write(CFG_SCREEN_WIDTH, CFG_DATA_W'(s));
        cfg_write(CFG_UNUSED_IDX, CFG_DATA_W'(junk));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int pick_side();
        int r;
        r = $urandom_range(15);
        if (r == 0)
            return 0;
        if (r == 1)
            return $urandom_range(MAX_DIM + 1, 8191);
        return $urandom_range(1, 12);
    endfunction

    function automatic int pick_stride();
        int r;
        r = $urandom_range(15);
        if (r == 0)
            return 0;
        if (r == 1)
            return 8191;
        return $urandom_range(1, 8191);
    endfunction

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        src_blue  <= '0;
        src_green <= '0;
        src_red   <= '0;
        alpha     <= '0;
        dst_blue  <= '0;
        dst_green <= '0;
        dst_red   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset window is a single pixel: every beat ends the rectangle
        send_pixel(make_px(255, 0, 255, 0, 0, 255, 0));
        send_pixel(make_px(255, 255, 0, 255, 0, 0, 255));
        send_pixel(make_px(0, 255, 255, 128, 255, 0, 0));
        send_pixel(make_px(170, 85, 1, 1, 85, 170, 254));

        // 2x2 at the far corner with the widest stride: index wraps, then restarts
        program_window(4095, 4095, 2, 2, 8191, 8191);
        send_random(5);

        // zero width, height and stride
        program_window(4095, 4095, 0, 0, 0, 0);
        send_random(2);

        // oversized sides, left mid-row on purpose
        program_window(0, 0, 8191, 8191, 1, 5);
        send_random(3);

        // shrink under the running column counter; second row wraps the index
        program_window(17, 4095, 2, 3, 4096, 6);
        send_random(5);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            program_window($urandom_range(4095), $urandom_range(4095), pick_side(),
                           pick_side(), pick_stride(), $urandom_range(8191));
            flow = flow_mode_t'(phase / 3);
            // hold the output while input keeps coming so both stages fill
            if (phase == 0)
                hold_req = 1'b1;
            send_random(PX_PER_PHASE);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d blended pixels with %0d rectangle ends over %0d register writes,",
                 beats_checked, rect_ends, cfg_writes);
        $display("through free flow, input gaps, output stalls, both, and one long output hold.");
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
